// ===== src/kvpt_pkg.sv =====
// Package: shared constants, phase encoding and result record for the key/value tokenizer.
`default_nettype none
package kvpt_pkg;

    localparam int MAX_PAIRS    = 16;
    localparam int MAX_TEXT_LEN = 4096;

    localparam int OFF_W  = $clog2(MAX_TEXT_LEN);
    localparam int LEN_W  = $clog2(MAX_TEXT_LEN + 1);
    localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

    localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_TEXT_LEN);
    localparam logic [OFF_W-1:0]  MAX_OFF = OFF_W'(MAX_TEXT_LEN - 1);
    localparam logic [PAIR_W-1:0] PAIR_LIMIT = PAIR_W'(MAX_PAIRS);

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;

    localparam logic KIND_PAIR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic MODE_COOKIE = 1'b0;

    localparam int  PADDR_W        = 3;
    localparam logic REG_DELIM_MODE = 1'b0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        PH_KEY,
        PH_EQ,
        PH_VAL,
        PH_DLM,
        PH_TAIL,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic [OFF_W-1:0]  key_offset;
        logic [LEN_W-1:0]  key_length;
        logic [OFF_W-1:0]  value_offset;
        logic [LEN_W-1:0]  value_length;
        logic [PAIR_W-1:0] pair_number;
        logic [LEN_W-1:0]  stop_offset;
        logic              last_of_run;
    } t_result;

endpackage
`default_nettype wire

// ===== src/kvpt_in_if.sv =====
// Interface: text byte channel into the tokenizer.
`default_nettype none
interface kvpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, data_byte, byte_present, end_of_text, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_text, output ready);
endinterface
`default_nettype wire

// ===== src/kvpt_out_if.sv =====
// Interface: result channel out of the tokenizer.
`default_nettype none
interface kvpt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [kvpt_pkg::OFF_W-1:0]  key_offset;
    logic [kvpt_pkg::LEN_W-1:0]  key_length;
    logic [kvpt_pkg::OFF_W-1:0]  value_offset;
    logic [kvpt_pkg::LEN_W-1:0]  value_length;
    logic [kvpt_pkg::PAIR_W-1:0] pair_number;
    logic [kvpt_pkg::LEN_W-1:0]  stop_offset;
    logic                        last_of_run;

    modport source (output valid, result_kind, key_offset, key_length, value_offset,
                    value_length, pair_number, stop_offset, last_of_run, input ready);
    modport sink   (input valid, result_kind, key_offset, key_length, value_offset,
                    value_length, pair_number, stop_offset, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/key_value_pair_tokenizer_top.sv =====
// Top level: key=value pair tokenizer with result queue and APB register port.
`default_nettype none
// Splits a byte stream into key=value pairs, at most one text byte per item. A key runs
// up to '=', a run of '=' is skipped, the value runs up to a pair delimiter
// (';' or space in cookie mode, '&' in query mode, set by register 0 at APB
// address 0) and a run of delimiters is skipped. Each pair is reported with
// key/value offsets and lengths; parsing stops on an empty key or value, at
// end of text, or after MAX_PAIRS pairs, and a summary item then gives the
// pair count and stop offset. End of text re-arms the block for a new text.
// Rate: one input item per clock. The parser state is updated in the accept
// cycle and the zero, one or two results of the item go into a 4-entry
// result queue; input is taken while the queue has room for two results.
// The output drains one result per clock while o_result.ready is high, so a
// stream of items that each yield two results is held back by the output. The
// first result is queued in the cycle after its item is accepted. Change the
// mode only while the block is idle.
module key_value_pair_tokenizer_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    kvpt_in_if.sink                           i_text,
    kvpt_out_if.source                        o_result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kvpt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    // ---------------- configuration ----------------
    logic r_mode;
    logic reg_hit;

    assign reg_hit = (paddr[kvpt_pkg::PADDR_W-1:2] == kvpt_pkg::REG_DELIM_MODE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= kvpt_pkg::MODE_COOKIE;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_mode <= pwdata[0];
        end
    end

    // ---------------- parser state ----------------
    kvpt_pkg::t_phase            r_phase, n_phase;
    logic [kvpt_pkg::LEN_W-1:0]  r_pos, n_pos;
    logic [kvpt_pkg::OFF_W-1:0]  r_key_start, n_key_start;
    logic [kvpt_pkg::LEN_W-1:0]  r_key_len, n_key_len;
    logic [kvpt_pkg::OFF_W-1:0]  r_val_start, n_val_start;
    logic [kvpt_pkg::LEN_W-1:0]  r_val_len, n_val_len;
    logic [kvpt_pkg::PAIR_W-1:0] r_pairs, n_pairs;

    // ---------------- result queue ----------------
    kvpt_pkg::t_result            r_fifo [kvpt_pkg::FIFO_DEPTH];
    logic [kvpt_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [kvpt_pkg::FIFO_AW:0]   r_count;

    logic               accept, pop;
    logic               is_dl, is_eq;
    logic [7:0]         b;
    logic [1:0]         emit_cnt;
    kvpt_pkg::t_result  res0, res1, pair_rec, sum_rec;
    logic [kvpt_pkg::OFF_W-1:0] pos_off;

    assign i_text.ready = (r_count <= (kvpt_pkg::FIFO_AW+1)'(kvpt_pkg::FIFO_DEPTH - 2));
    assign accept       = i_text.valid && i_text.ready;
    assign pop          = o_result.valid && o_result.ready;

    assign b       = i_text.data_byte;
    assign is_eq   = (b == kvpt_pkg::CH_EQ);
    assign is_dl   = (r_mode == kvpt_pkg::MODE_COOKIE) ?
                     ((b == kvpt_pkg::CH_SEMI) || (b == kvpt_pkg::CH_SPACE)) :
                     (b == kvpt_pkg::CH_AMP);
    // offset form of the current position, clamped to the last legal offset
    assign pos_off = (r_pos > {1'b0, kvpt_pkg::MAX_OFF}) ? kvpt_pkg::MAX_OFF
                                                         : r_pos[kvpt_pkg::OFF_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_key_start = r_key_start;
        n_key_len   = r_key_len;
        n_val_start = r_val_start;
        n_val_len   = r_val_len;
        n_pairs     = r_pairs;
        emit_cnt    = 2'd0;
        res0        = '0;
        res1        = '0;
        pair_rec    = '0;
        sum_rec     = '0;

        // byte path: at most one result, always in slot 0
        if (accept && i_text.byte_present && (r_phase != kvpt_pkg::PH_DONE)) begin
            case (r_phase)
                kvpt_pkg::PH_KEY: begin
                    if (is_eq) begin
                        n_phase = kvpt_pkg::PH_EQ;
                    end else if (r_key_len != kvpt_pkg::MAX_LEN) begin
                        n_key_len = r_key_len + 1'b1;
                    end
                end
                kvpt_pkg::PH_EQ: begin
                    if (!is_eq) begin
                        n_val_start = pos_off;
                        if (is_dl) begin
                            n_val_len = '0;
                            n_phase   = kvpt_pkg::PH_TAIL;
                        end else begin
                            n_val_len = kvpt_pkg::LEN_W'(1);
                            n_phase   = kvpt_pkg::PH_VAL;
                        end
                    end
                end
                kvpt_pkg::PH_VAL: begin
                    if (!is_dl) begin
                        if (r_val_len != kvpt_pkg::MAX_LEN) begin
                            n_val_len = r_val_len + 1'b1;
                        end
                    end else if (r_key_len != '0) begin
                        res0.kind         = kvpt_pkg::KIND_PAIR;
                        res0.key_offset   = r_key_start;
                        res0.key_length   = r_key_len;
                        res0.value_offset = r_val_start;
                        res0.value_length = r_val_len;
                        res0.pair_number  = r_pairs;
                        emit_cnt          = 2'd1;
                        n_pairs           = r_pairs + 1'b1;
                        n_phase = (n_pairs >= kvpt_pkg::PAIR_LIMIT) ? kvpt_pkg::PH_TAIL
                                                                    : kvpt_pkg::PH_DLM;
                    end else begin
                        n_phase = kvpt_pkg::PH_TAIL;
                    end
                end
                kvpt_pkg::PH_DLM: begin
                    if (!is_dl) begin
                        n_key_start = pos_off;
                        if (is_eq) begin
                            n_key_len = '0;
                            n_phase   = kvpt_pkg::PH_EQ;
                        end else begin
                            n_key_len = kvpt_pkg::LEN_W'(1);
                            n_phase   = kvpt_pkg::PH_KEY;
                        end
                    end
                end
                kvpt_pkg::PH_TAIL: begin
                    // first non-delimiter after the final skip: stop here
                    if (!is_dl) begin
                        res0.kind        = kvpt_pkg::KIND_SUMMARY;
                        res0.pair_number = r_pairs;
                        res0.stop_offset = r_pos;
                        emit_cnt         = 2'd1;
                        n_phase          = kvpt_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
            if (r_pos != kvpt_pkg::MAX_LEN) begin
                n_pos = r_pos + 1'b1;
            end
        end

        // end of text: flush a pending pair, then the summary unless already out.
        // A pending pair only exists when the byte path emitted nothing.
        if (accept && i_text.end_of_text) begin
            if ((n_phase == kvpt_pkg::PH_VAL) && (n_key_len != '0) && (n_val_len != '0)) begin
                pair_rec.kind         = kvpt_pkg::KIND_PAIR;
                pair_rec.key_offset   = n_key_start;
                pair_rec.key_length   = n_key_len;
                pair_rec.value_offset = n_val_start;
                pair_rec.value_length = n_val_len;
                pair_rec.pair_number  = n_pairs;
                res0                  = pair_rec;
                emit_cnt              = 2'd1;
                n_pairs               = n_pairs + 1'b1;
            end
            if (n_phase != kvpt_pkg::PH_DONE) begin
                sum_rec.kind        = kvpt_pkg::KIND_SUMMARY;
                sum_rec.pair_number = n_pairs;
                sum_rec.stop_offset = n_pos;
                if (emit_cnt == 2'd0) begin
                    res0 = sum_rec;
                end else begin
                    res1 = sum_rec;
                end
                emit_cnt = emit_cnt + 2'd1;
            end
            n_phase     = kvpt_pkg::PH_KEY;
            n_pos       = '0;
            n_key_start = '0;
            n_key_len   = '0;
            n_val_start = '0;
            n_val_len   = '0;
            n_pairs     = '0;
        end

        if (emit_cnt == 2'd1) begin
            res0.last_of_run = 1'b1;
        end
        if (emit_cnt == 2'd2) begin
            res1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= kvpt_pkg::PH_KEY;
            r_pos       <= '0;
            r_key_start <= '0;
            r_key_len   <= '0;
            r_val_start <= '0;
            r_val_len   <= '0;
            r_pairs     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_key_start <= n_key_start;
            r_key_len   <= n_key_len;
            r_val_start <= n_val_start;
            r_val_len   <= n_val_len;
            r_pairs     <= n_pairs;
        end
    end

    // queue payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (emit_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (emit_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + kvpt_pkg::FIFO_AW'(emit_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (kvpt_pkg::FIFO_AW+1)'(emit_cnt)
                       - (kvpt_pkg::FIFO_AW+1)'(pop);
        end
    end

    assign o_result.valid        = (r_count != '0);
    assign o_result.result_kind  = r_fifo[r_rd_ptr].kind;
    assign o_result.key_offset   = r_fifo[r_rd_ptr].key_offset;
    assign o_result.key_length   = r_fifo[r_rd_ptr].key_length;
    assign o_result.value_offset = r_fifo[r_rd_ptr].value_offset;
    assign o_result.value_length = r_fifo[r_rd_ptr].value_length;
    assign o_result.pair_number  = r_fifo[r_rd_ptr].pair_number;
    assign o_result.stop_offset  = r_fifo[r_rd_ptr].stop_offset;
    assign o_result.last_of_run  = r_fifo[r_rd_ptr].last_of_run;

endmodule
`default_nettype wire
